// ===== src/phd_pkg.sv =====
package phd_pkg;

	// Fixed field widths
	localparam int FUNC_W     = 2;
	localparam int PART_W     = 10;
	localparam int COORD_W    = 32;
	localparam int DISP_W     = COORD_W + 1;
	localparam int STEP_W     = 5;
	localparam int STATUS_W   = 2;
	localparam int DEPTH_W    = 5;
	localparam int PCOUNT_W   = 11;
	localparam int FRAMES_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// Item function codes
	localparam logic [FUNC_W-1:0] FN_FRAME = 2'd0;
	localparam logic [FUNC_W-1:0] FN_STORE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_TOO_LONG = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'd1;

	// Register reset values and the frame counter limit
	localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 5'd16;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;
	localparam logic [FRAMES_W-1:0] FRAMES_MAX   = 8'd255;

	typedef enum logic [2:0] {
		S_INIT_CLR,
		S_IDLE,
		S_REDUCE,
		S_EXEC,
		S_FRAME_CLR,
		S_PUT
	} state_t;

	typedef struct packed {
		logic take;
		logic reduce;
		logic exec;
		logic clr_step;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic part_big;
		logic is_frame;
		logic clr_done;
		logic out_free;
	} sts_t;

endpackage

// ===== src/phd_ctrl.sv =====
module phd_ctrl import phd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT_CLR: begin
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_REDUCE;
				end
			end
			S_REDUCE: begin
				// fold the particle index one stride per cycle
				if (sts.part_big) begin
					cmd.reduce = 1'b1;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.is_frame ? S_FRAME_CLR : S_PUT;
			end
			S_FRAME_CLR: begin
				if (sts.clr_done) begin
					state_d = S_PUT;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/phd_dp.sv =====
module phd_dp import phd_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int MAX_HISTORY   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic [FUNC_W-1:0]          func,
	input  logic [PART_W-1:0]          particle,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic                       present,
	input  logic [STEP_W-1:0]          steps_back,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DISP_W-1:0]   disp_x,
	output logic signed [DISP_W-1:0]   disp_y,
	output logic signed [DISP_W-1:0]   disp_z,
	output logic                       was_present,
	output logic [STATUS_W-1:0]        status
);

	localparam int ENTRIES = MAX_HISTORY * MAX_PARTICLES;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SLOT_W  = $clog2(MAX_HISTORY);
	localparam int DW      = SLOT_W + 1;
	localparam int LW      = ((SLOT_W > STEP_W) ? SLOT_W : STEP_W) + 2;

	// item registers
	logic [FUNC_W-1:0]   func_q;
	logic [PART_W-1:0]   part_q;
	logic [COORD_W-1:0]  px_q, py_q, pz_q;
	logic                pres_in_q;
	logic [STEP_W-1:0]   step_q;

	// configuration and ring state
	logic [DEPTH_W-1:0]  hd_q;
	logic [PCOUNT_W-1:0] pc_q;
	logic [SLOT_W-1:0]   cur_slot_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [CNT_W-1:0]    clr_left_q;
	logic [STATUS_W-1:0] status_q;
	logic                ok_q;

	// memories
	logic [COORD_W-1:0]  mem_x [ENTRIES];
	logic [COORD_W-1:0]  mem_y [ENTRIES];
	logic [COORD_W-1:0]  mem_z [ENTRIES];
	logic                mem_p [ENTRIES];
	logic [COORD_W-1:0]  rd_x_q, rd_y_q, rd_z_q;
	logic                rd_p_q;

	logic                out_valid_q;

	logic [DW-1:0]       depth_eff;
	logic [STATUS_W-1:0] q_status;
	logic [SLOT_W-1:0]   back_slot;
	logic [LW-1:0]       nxt_slot;
	logic [SLOT_W-1:0]   new_slot;
	logic [ADDR_W-1:0]   cur_addr, back_addr, new_base;
	logic [CNT_W-1:0]    n_clear;
	logic                pos_we, rd_en, pres_we, pres_wd;
	logic [ADDR_W-1:0]   pres_addr;

	always_comb begin
		if (hd_q == '0) begin
			depth_eff = DW'(1);
		end else if (32'(hd_q) > MAX_HISTORY) begin
			depth_eff = DW'(MAX_HISTORY);
		end else begin
			depth_eff = DW'(hd_q);
		end
	end

	always_comb begin
		if (step_q == '0 || {{(FRAMES_W-STEP_W){1'b0}}, step_q} >= frames_q) begin
			q_status = STS_RANGE;
		end else if (LW'(step_q) >= LW'(depth_eff)) begin
			q_status = STS_TOO_LONG;
		end else begin
			q_status = STS_OK;
		end
		if (LW'(cur_slot_q) >= LW'(step_q)) begin
			back_slot = SLOT_W'(LW'(cur_slot_q) - LW'(step_q));
		end else begin
			back_slot = SLOT_W'(LW'(cur_slot_q) + LW'(depth_eff) - LW'(step_q));
		end
	end

	assign nxt_slot  = LW'(cur_slot_q) + LW'(1);
	assign new_slot  = (nxt_slot >= LW'(depth_eff)) ? '0 : SLOT_W'(nxt_slot);
	assign cur_addr  = ADDR_W'(cur_slot_q) * ADDR_W'(MAX_PARTICLES) + ADDR_W'(part_q);
	assign back_addr = ADDR_W'(back_slot) * ADDR_W'(MAX_PARTICLES) + ADDR_W'(part_q);
	assign new_base  = ADDR_W'(new_slot) * ADDR_W'(MAX_PARTICLES);
	assign n_clear   = (32'(pc_q) > MAX_PARTICLES) ? CNT_W'(MAX_PARTICLES) : CNT_W'(pc_q);

	assign pos_we    = cmd.exec && (func_q == FN_STORE);
	assign rd_en     = cmd.exec && (func_q == FN_QUERY) && (q_status == STS_OK);
	assign pres_we   = pos_we || cmd.clr_step;
	assign pres_addr = cmd.clr_step ? clr_addr_q : cur_addr;
	assign pres_wd   = cmd.clr_step ? 1'b0 : pres_in_q;

	assign sts.part_big = 32'(part_q) >= MAX_PARTICLES;
	assign sts.is_frame = func_q == FN_FRAME;
	assign sts.clr_done = clr_left_q == '0;
	assign sts.out_free = !out_valid_q || !out_stall;

	// capture the beat, then fold the particle index
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q    <= func;
			part_q    <= particle;
			px_q      <= pos_x;
			py_q      <= pos_y;
			pz_q      <= pos_z;
			pres_in_q <= present;
			step_q    <= steps_back;
		end else if (cmd.reduce) begin
			part_q <= part_q - PART_W'(MAX_PARTICLES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q <= DEPTH_RESET;
			pc_q <= PCOUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HISTORY_DEPTH:  hd_q <= cfg_data[DEPTH_W-1:0];
				REG_PARTICLE_COUNT: pc_q <= cfg_data[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q <= SLOT_W'(MAX_HISTORY - 1);
			frames_q   <= '0;
			clr_addr_q <= '0;
			clr_left_q <= CNT_W'(ENTRIES);
		end else begin
			if (cmd.exec && func_q == FN_FRAME) begin
				cur_slot_q <= new_slot;
				clr_addr_q <= new_base;
				clr_left_q <= n_clear;
				if (frames_q != FRAMES_MAX) begin
					frames_q <= frames_q + FRAMES_W'(1);
				end
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				clr_left_q <= clr_left_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= (func_q == FN_QUERY) ? q_status : STS_OK;
			ok_q     <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			mem_x[cur_addr] <= px_q;
			mem_y[cur_addr] <= py_q;
			mem_z[cur_addr] <= pz_q;
		end
		if (rd_en) begin
			rd_x_q <= mem_x[back_addr];
			rd_y_q <= mem_y[back_addr];
			rd_z_q <= mem_z[back_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			mem_p[pres_addr] <= pres_wd;
		end
		if (rd_en) begin
			rd_p_q <= mem_p[back_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			if (ok_q) begin
				disp_x      <= {px_q[COORD_W-1], px_q} - {rd_x_q[COORD_W-1], rd_x_q};
				disp_y      <= {py_q[COORD_W-1], py_q} - {rd_y_q[COORD_W-1], rd_y_q};
				disp_z      <= {pz_q[COORD_W-1], pz_q} - {rd_z_q[COORD_W-1], rd_z_q};
				was_present <= rd_p_q;
			end else begin
				disp_x      <= '0;
				disp_y      <= '0;
				disp_z      <= '0;
				was_present <= 1'b0;
			end
			status <= status_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/position_history_displacement_core.sv =====
// Channel   Direction  Handshake            Beat carries
// --------  ---------  -------------------  ------------------------------------------------
// in        input      in_valid / in_stall  func, particle, pos_x/y/z, present, steps_back
// out       output     out_valid/out_stall  disp_x/y/z, was_present, status
// cfg       input      cfg_wr_en            cfg_index, cfg_data (no read-back)
//
// Store, query and unused code: each stride of MAX_PARTICLES is folded off the particle
// index in turn (none while it is in range) before the beat executes and its result loads.
// Frame start: min(particle_count, MAX_PARTICLES) presence bits are swept; the presence memory has one
// write port, so one bit is cleared per cycle.
// After reset in_stall stays high while all MAX_HISTORY * MAX_PARTICLES entries are swept;
// configuration writes are taken throughout. A stalled result only delays the next load.
module position_history_displacement_core import phd_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int MAX_HISTORY   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [FUNC_W-1:0]          func,
	input  logic [PART_W-1:0]          particle,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic                       present,
	input  logic [STEP_W-1:0]          steps_back,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DISP_W-1:0]   disp_x,
	output logic signed [DISP_W-1:0]   disp_y,
	output logic signed [DISP_W-1:0]   disp_z,
	output logic                       was_present,
	output logic [STATUS_W-1:0]        status,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	// Commands from the sequencer, status back from the ring datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: capture, fold index, execute, clear sweep, load result
	phd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: slot ring, position and presence memories, subtractors, result register
	phd_dp #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.MAX_HISTORY   (MAX_HISTORY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.particle    (particle),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.present     (present),
		.steps_back  (steps_back),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.disp_x      (disp_x),
		.disp_y      (disp_y),
		.disp_z      (disp_z),
		.was_present (was_present),
		.status      (status)
	);

endmodule

// ===== test/position_history_displacement_core_test.sv =====
module position_history_displacement_core_test;
	import phd_pkg::*;

	localparam int MAX_P     = 1024;
	localparam int MAX_H     = 16;
	localparam int ENTRIES   = MAX_P * MAX_H;
	localparam int POOL_SIZE = 6;
	localparam int RUN_LIMIT = 1000000;

	// The one function code the block leaves unused; such a beat must change nothing
	localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [PART_W-1:0]  particle;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] pos_z;
		logic               present;
		logic [STEP_W-1:0]  steps_back;
	} beat_t;

	typedef struct packed {
		logic [DISP_W-1:0]   disp_x;
		logic [DISP_W-1:0]   disp_y;
		logic [DISP_W-1:0]   disp_z;
		logic                was_present;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	// Shadow of the ring: positions, presence bits and a written mark per entry,
	// plus the queue of results still owed by the block.
	class displacement_board;
		logic [DEPTH_W-1:0]  depth_reg;
		logic [PCOUNT_W-1:0] pcount_reg;
		int unsigned         slot_now;
		int unsigned         frames;
		logic [COORD_W-1:0]  px [ENTRIES];
		logic [COORD_W-1:0]  py [ENTRIES];
		logic [COORD_W-1:0]  pz [ENTRIES];
		bit                  pres [ENTRIES];
		bit                  written [ENTRIES];
		outcome_t            expected_disp [$];
		int unsigned         errors, checked;
		int unsigned         frame_count, store_count, query_ok, query_refused;

		function new();
			depth_reg  = DEPTH_RESET;
			pcount_reg = PCOUNT_RESET;
			slot_now   = MAX_H - 1;
			frames     = 0;
		endfunction

		function int unsigned depth_eff();
			if (depth_reg == 0) return 1;
			if (depth_reg > MAX_H) return MAX_H;
			return 32'(depth_reg);
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_HISTORY_DEPTH) depth_reg = val[DEPTH_W-1:0];
			else pcount_reg = val[PCOUNT_W-1:0];
		endfunction

		function logic [STATUS_W-1:0] query_status(logic [STEP_W-1:0] back);
			if (back == 0 || back >= frames) return STS_RANGE;
			if (back >= depth_eff()) return STS_TOO_LONG;
			return STS_OK;
		endfunction

		// Slot holding the frame that lies back frames behind the current one
		function int unsigned lookback(logic [STEP_W-1:0] back);
			if (slot_now >= back) return slot_now - back;
			return slot_now + depth_eff() - back;
		endfunction

		function bit reads_blank(logic [PART_W-1:0] part, logic [STEP_W-1:0] back);
			if (query_status(back) != STS_OK) return 1'b0;
			return !written[lookback(back) * MAX_P + part];
		endfunction

		// Sign-extend both coordinates and subtract; exact in DISP_W bits
		function logic [DISP_W-1:0] widen_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
			return {a[COORD_W-1], a} - {b[COORD_W-1], b};
		endfunction

		function void note_beat(beat_t b);
			outcome_t    want;
			int unsigned idx, n;
			want = '0;
			case (b.func)
				FN_FRAME: begin
					slot_now = (slot_now + 1 >= depth_eff()) ? 0 : slot_now + 1;
					n = (pcount_reg > MAX_P) ? MAX_P : 32'(pcount_reg);
					for (int i = 0; i < n; i++) pres[slot_now * MAX_P + i] = 1'b0;
					if (frames < FRAMES_MAX) frames++;
					frame_count++;
				end
				FN_STORE: begin
					idx = slot_now * MAX_P + b.particle;
					px[idx]      = b.pos_x;
					py[idx]      = b.pos_y;
					pz[idx]      = b.pos_z;
					pres[idx]    = b.present;
					written[idx] = 1'b1;
					store_count++;
				end
				FN_QUERY: begin
					want.status = query_status(b.steps_back);
					if (want.status == STS_OK) begin
						idx = lookback(b.steps_back) * MAX_P + b.particle;
						want.disp_x      = widen_diff(b.pos_x, px[idx]);
						want.disp_y      = widen_diff(b.pos_y, py[idx]);
						want.disp_z      = widen_diff(b.pos_z, pz[idx]);
						want.was_present = pres[idx];
						query_ok++;
					end else begin
						query_refused++;
					end
				end
				default: ;
			endcase
			expected_disp.push_back(want);
		endfunction

		// One line per mismatch; keep the log short if the block is badly broken
		task report(string what, logic [DISP_W-1:0] seen, logic [DISP_W-1:0] wanted);
			errors++;
			if (errors <= 40)
				$display("result %0d, %s: got %h, want %h", checked, what, seen, wanted);
		endtask

		task check_outcome(outcome_t got);
			outcome_t want;
			if (expected_disp.size() == 0) begin
				report("result with nothing owed", DISP_W'(got.status), '0);
				return;
			end
			want = expected_disp.pop_front();
			checked++;
			if (got.disp_x !== want.disp_x) report("disp_x", got.disp_x, want.disp_x);
			if (got.disp_y !== want.disp_y) report("disp_y", got.disp_y, want.disp_y);
			if (got.disp_z !== want.disp_z) report("disp_z", got.disp_z, want.disp_z);
			if (got.was_present !== want.was_present)
				report("was_present", DISP_W'(got.was_present), DISP_W'(want.was_present));
			if (got.status !== want.status)
				report("status", DISP_W'(got.status), DISP_W'(want.status));
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [FUNC_W-1:0]          func;
	logic [PART_W-1:0]          particle;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  pos_z;
	logic                       present;
	logic [STEP_W-1:0]          steps_back;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [DISP_W-1:0]   disp_x;
	logic signed [DISP_W-1:0]   disp_y;
	logic signed [DISP_W-1:0]   disp_z;
	logic                       was_present;
	logic [STATUS_W-1:0]        status;
	logic                       cfg_wr_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	displacement_board board;
	logic [PART_W-1:0] pool [POOL_SIZE];
	int unsigned       burst_left;
	bit                gaps_on;
	int unsigned       beats_sent;
	int unsigned       cycle_count = 0;
	int unsigned       stall_tick = 0;
	int unsigned       stall_mode = 0;

	position_history_displacement_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.particle    (particle),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.present     (present),
		.steps_back  (steps_back),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.disp_x      (disp_x),
		.disp_y      (disp_y),
		.disp_z      (disp_z),
		.was_present (was_present),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes far inside this
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: check the beat taken at this edge, then pick the stall for the
	// next cycle. The stall mode is drawn at random among four patterns: none,
	// light random, heavy random, or a fixed three-in-eight duty.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_outcome('{disp_x, disp_y, disp_z, was_present, status});
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= (stall_tick % 8 < 3);
		endcase
	end

	function automatic beat_t make_beat(logic [FUNC_W-1:0] f, logic [PART_W-1:0] p,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
			logic pr, logic [STEP_W-1:0] back);
		beat_t b;
		b.func       = f;
		b.particle   = p;
		b.pos_x      = x;
		b.pos_y      = y;
		b.pos_z      = z;
		b.present    = pr;
		b.steps_back = back;
		return b;
	endfunction

	// Mostly full-range random, now and then one of the corner values
	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Well-formed traffic: frame starts, stores and queries on a small pool of
	// particles so that queries land on stored entries; a tenth of the indexes
	// are random and a few beats carry the unused code.
	function automatic beat_t random_beat(int frame_pct);
		beat_t             b;
		int unsigned       roll;
		logic [STEP_W-1:0] back;
		b.particle   = ($urandom_range(0, 9) == 0) ? PART_W'($urandom_range(0, MAX_P - 1))
		                                          : pool[$urandom_range(0, POOL_SIZE - 1)];
		b.pos_x      = random_coord();
		b.pos_y      = random_coord();
		b.pos_z      = random_coord();
		b.present    = 1'($urandom_range(0, 1));
		b.steps_back = ($urandom_range(0, 4) == 0) ? STEP_W'($urandom_range(0, 31))
		                                          : STEP_W'($urandom_range(1, board.depth_eff()));
		roll = $urandom_range(0, 99);
		if (roll < frame_pct) b.func = FN_FRAME;
		else begin
			roll = $urandom_range(0, 99);
			if (roll < 4) b.func = FN_NONE;
			else if (roll < 50) b.func = FN_STORE;
			else b.func = FN_QUERY;
		end
		// Never read a position that was never stored: move to a pool particle that
		// has one, or else turn the query into a refused one
		if (b.func == FN_QUERY && board.reads_blank(b.particle, b.steps_back)) begin
			back = b.steps_back;
			b.steps_back = '0;
			for (int k = 0; k < POOL_SIZE; k++)
				if (!board.reads_blank(pool[k], back)) begin
					b.particle   = pool[k];
					b.steps_back = back;
				end
		end
		return b;
	endfunction

	// Present one beat and hold it until the block takes it
	task automatic send_beat(beat_t b);
		func       <= b.func;
		particle   <= b.particle;
		pos_x      <= b.pos_x;
		pos_y      <= b.pos_y;
		pos_z      <= b.pos_z;
		present    <= b.present;
		steps_back <= b.steps_back;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_beat(b);
		beats_sent++;
	endtask

	// Close a burst with a random gap, unless this phase runs without gaps
	task automatic pace();
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.note_config(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every owed result, then let the block come to rest
	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_disp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] depth_val,
			logic [CFG_DATA_W-1:0] pcount_val, int beats, int frame_pct);
		settle();
		write_reg(REG_HISTORY_DEPTH, depth_val);
		write_reg(REG_PARTICLE_COUNT, pcount_val);
		// Keep at least half the pool so older slots still hold some of its entries
		for (int i = 0; i < POOL_SIZE / 2; i++)
			pool[$urandom_range(0, POOL_SIZE - 1)] = PART_W'($urandom_range(0, MAX_P - 1));
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < beats; i++) begin
			send_beat(random_beat(frame_pct));
			pace();
		end
	endtask

	initial begin
		board = new();
		for (int i = 0; i < POOL_SIZE; i++) pool[i] = PART_W'($urandom_range(0, MAX_P - 1));
		burst_left = 1;
		gaps_on    = 1'b1;
		beats_sent = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= FN_FRAME;
		particle   <= '0;
		pos_x      <= '0;
		pos_y      <= '0;
		pos_z      <= '0;
		present    <= 1'b0;
		steps_back <= '0;
		cfg_wr_en  <= 1'b0;
		cfg_index  <= REG_HISTORY_DEPTH;
		cfg_data   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset settings. Store before any frame start lands in
		// the last slot; the unused code must leave everything alone.
		send_beat(make_beat(FN_STORE, 10'd1023, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 1'b1, 5'd31));
		send_beat(make_beat(FN_QUERY, 10'd1023, '0, '0, '0, 1'b0, 5'd0));
		send_beat(make_beat(FN_NONE, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 1'b1, 5'd31));
		send_beat(make_beat(FN_FRAME, '0, '0, '0, '0, 1'b0, '0));
		send_beat(make_beat(FN_STORE, 10'd0, 32'h8000_0000, 32'h7fff_ffff, '0, 1'b1, '0));
		// Only one frame seen so far: one step back is refused
		send_beat(make_beat(FN_QUERY, 10'd0, '0, '0, '0, 1'b0, 5'd1));
		send_beat(make_beat(FN_FRAME, '0, '0, '0, '0, 1'b0, '0));
		send_beat(make_beat(FN_STORE, 10'd0, 32'h7fff_ffff, 32'h8000_0000,
			32'h1234_5678, 1'b0, '0));
		// Widest positive and negative displacements
		send_beat(make_beat(FN_QUERY, 10'd0, 32'h7fff_ffff, 32'h8000_0000, '0, 1'b0, 5'd1));
		send_beat(make_beat(FN_QUERY, 10'd0, '0, '0, '0, 1'b0, 5'd31));
		send_beat(make_beat(FN_QUERY, 10'd0, '0, '0, '0, 1'b0, 5'd2));

		// Lower the depth to two with the current slot at one: the next frame
		// start wraps to slot zero and lookback must wrap round the ring
		settle();
		write_reg(REG_HISTORY_DEPTH, 11'd2);
		write_reg(REG_PARTICLE_COUNT, 11'd5);
		send_beat(make_beat(FN_FRAME, '0, '0, '0, '0, 1'b0, '0));
		send_beat(make_beat(FN_STORE, 10'd1023, 32'h0001_8000, 32'hfffe_8000,
			32'h0000_0001, 1'b1, '0));
		send_beat(make_beat(FN_QUERY, 10'd0, 32'h0000_0000, 32'h0000_0001,
			32'hffff_ffff, 1'b0, 5'd1));
		// Interval longer than the ring
		send_beat(make_beat(FN_QUERY, 10'd0, '0, '0, '0, 1'b0, 5'd2));
		send_beat(make_beat(FN_FRAME, '0, '0, '0, '0, 1'b0, '0));
		send_beat(make_beat(FN_QUERY, 10'd1023, 32'h7fff_ffff, 32'h8000_0000,
			32'h0000_0000, 1'b0, 5'd1));
		// Presence cleared by the frame start, position kept
		send_beat(make_beat(FN_QUERY, 10'd0, 32'h0000_0010, 32'h0000_0020,
			32'h0000_0030, 1'b0, 5'd1));

		// Random phases: full depth, depth three from a wide write, depth zero
		// with nothing cleared, both registers over range, a frame-heavy
		// stretch with one particle cleared, and a mid-size finish
		run_phase(11'd16, 11'd64, 250, 12);
		run_phase(11'h7e3, 11'd1024, 150, 6);
		run_phase(11'd0, 11'd0, 120, 20);
		run_phase(11'd31, 11'd2047, 150, 5);
		run_phase(11'd7, 11'd1, 300, 55);
		run_phase(11'd16, 11'd300, 230, 10);

		settle();
		repeat (32) @(posedge clk);
		if (board.expected_disp.size() != 0)
			board.report("results never arrived", DISP_W'(board.expected_disp.size()), '0);

		$display("%0d beats sent, %0d results checked, %0d mismatches",
			beats_sent, board.checked, board.errors);
		$display("%0d frame starts, %0d stores, %0d queries answered, %0d refused",
			board.frame_count, board.store_count, board.query_ok, board.query_refused);
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
